@@ rtl/core/pcpfl_pkg.sv @@
// Package for the per-CPU page free list allocator: field widths, status and
// command codes, register indexes and the sequencer state type.
// No dependencies.
package pcpfl_pkg;

  localparam int ADDR_W    = 40;
  localparam int CPU_ID_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int STAT_W    = 2;

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_BAD   = 2'd2;

  localparam logic CMD_FREE  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP  = 2'd1;

  localparam logic [ADDR_W-1:0] BASE_RST = 40'h00_8000_0000;
  localparam logic [ADDR_W-1:0] TOP_RST  = 40'h00_8800_0000;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

endpackage

@@ rtl/core/pcpfl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; no reset, contents undefined until written.
module pcpfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/per_cpu_page_free_list.sv @@
// Top level of the per-CPU page free list allocator: list heads in flops,
// next-page links in a pcpfl_ram instance. Uses pcpfl_pkg and pcpfl_ram.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | to block  | in_valid / in_stall   | in_cmd, in_cpu_id, in_phys_addr
//  out     | from blk  | out_valid / out_stall | out_status, out_page_addr
//  cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// A request is accepted in S_IDLE, which picks the list and issues the link RAM
// read; S_EXEC then takes the read data and updates the head (or pushes the link).
// The single read port of the link RAM sets this split.
// Reset empties all lists at once through per-CPU valid bits; no clearing pass.
// A finished result sits in the output register; a new request is taken while
// it waits, and S_EXEC holds until the output register is free.
// PAGE_BYTES must be a power of two.
module per_cpu_page_free_list
  import pcpfl_pkg::*;
#(
  parameter int CPU_COUNT  = 8,
  parameter int PAGE_COUNT = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [CPU_ID_W-1:0]  in_cpu_id,
  input  logic [ADDR_W-1:0]    in_phys_addr,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [ADDR_W-1:0]    out_page_addr,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int CPU_W   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int PIDX_W  = $clog2(PAGE_COUNT);
  localparam int OFS_W   = $clog2(PAGE_BYTES);
  localparam int APG_W   = ADDR_W - OFS_W;      // page number of an address
  localparam int FPG_W   = APG_W + 1;           // rounded-up base may carry out
  localparam int LINK_W  = PIDX_W + 1;          // {valid, next index}

  // configuration
  logic [ADDR_W-1:0] base_r, top_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RST;
      top_r  <= TOP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE: base_r <= cfg_wdata;
        REG_TOP:  top_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // first managed page number: base rounded up to a page boundary
  logic [FPG_W-1:0] fp_pg;
  assign fp_pg = FPG_W'(base_r[ADDR_W-1:OFS_W]) + FPG_W'(|base_r[OFS_W-1:0]);

  // list heads
  logic [PIDX_W-1:0]    hd_idx_r [CPU_COUNT];
  logic [CPU_COUNT-1:0] hd_vld_r;

  // sequencer
  fsm_t state_r, state_nxt;
  logic accept, exec_done, ram_re;

  // request registers
  logic              op_r;
  logic [CPU_W-1:0]  cpu_r, pick_r;
  logic              any_r;
  logic              pre_ok_r;
  logic [APG_W-1:0]  diff_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r;
  logic [ADDR_W-1:0] page_r;

  // link RAM
  logic              link_we;
  logic [PIDX_W-1:0] link_waddr, link_raddr;
  logic [LINK_W-1:0] link_wdata, link_rdata;

  // list selection at accept: own list first, else lowest other non-empty
  logic [CPU_W-1:0] own, oth, pick;
  logic             oth_found, any;

  // cpu number folded into range through a small constant table
  always_comb begin
    own = '0;
    for (int v = 0; v < 2**CPU_ID_W; v++) begin
      if (in_cpu_id == CPU_ID_W'(v)) own = CPU_W'(v % CPU_COUNT);
    end
  end

  always_comb begin
    oth_found = 1'b0;
    oth       = '0;
    for (int c = 0; c < CPU_COUNT; c++) begin
      if (!oth_found && hd_vld_r[c] && (CPU_W'(c) != own)) begin
        oth_found = 1'b1;
        oth       = CPU_W'(c);
      end
    end
  end

  assign pick       = hd_vld_r[own] ? own : oth;
  assign any        = hd_vld_r[own] || oth_found;
  assign link_raddr = hd_idx_r[pick];

  // free address checks, first half
  logic [FPG_W-1:0] addr_pg;
  logic             aligned, ge_first, lt_top;

  assign addr_pg  = FPG_W'(in_phys_addr[ADDR_W-1:OFS_W]);
  assign aligned  = (in_phys_addr[OFS_W-1:0] == '0);
  assign ge_first = (addr_pg >= fp_pg);
  assign lt_top   = (in_phys_addr < top_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_cmd;
      cpu_r    <= own;
      pick_r   <= pick;
      any_r    <= any;
      pre_ok_r <= aligned && ge_first && lt_top;
      diff_r   <= APG_W'(addr_pg - fp_pg);
    end
  end

  // second half: page index range check
  logic free_ok;
  assign free_ok = pre_ok_r && (diff_r < APG_W'(PAGE_COUNT));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    exec_done = 1'b0;
    unique case (state_r)
      S_IDLE: in_stall  = 1'b0;
      S_EXEC: exec_done = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign ram_re = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // push: old head becomes the new page's link
  assign link_we    = exec_done && (op_r == CMD_FREE) && free_ok;
  assign link_waddr = diff_r[PIDX_W-1:0];
  assign link_wdata = {hd_vld_r[cpu_r], hd_idx_r[cpu_r]};

  pcpfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (PAGE_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (ram_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  logic pop;
  assign pop = exec_done && (op_r == CMD_ALLOC) && any_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_vld_r <= '0;
    end else if (link_we) begin
      hd_vld_r[cpu_r] <= 1'b1;
    end else if (pop) begin
      hd_vld_r[pick_r] <= link_rdata[PIDX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      hd_idx_r[cpu_r] <= diff_r[PIDX_W-1:0];
    end else if (pop) begin
      hd_idx_r[pick_r] <= link_rdata[PIDX_W-1:0];
    end
  end

  // result; the popped index is the picked head, the address of the RAM read at accept
  logic [FPG_W-1:0] alloc_pg;
  assign alloc_pg = fp_pg + FPG_W'(hd_idx_r[pick_r]);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (exec_done) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      if (op_r == CMD_FREE) begin
        status_r <= free_ok ? ST_DONE : ST_BAD;
        page_r   <= '0;
      end else if (any_r) begin
        status_r <= ST_DONE;
        page_r   <= {alloc_pg[APG_W-1:0], {OFS_W{1'b0}}};
      end else begin
        status_r <= ST_EMPTY;
        page_r   <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_page_addr = page_r;

  // a result only appears after a request's S_EXEC state
  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result without request in progress");

  // only a successful allocate carries an address
  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_DONE)) |-> (page_r == '0))
    else $error("nonzero page address on failed or free result");

  // empty status only when every list was empty
  a_empty_all: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_done && (op_r == CMD_ALLOC) && !any_r) |-> (hd_vld_r == '0))
    else $error("empty reported while a list holds pages");

  // a push leaves the requester's list non-empty
  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    link_we |=> hd_vld_r[$past(cpu_r)])
    else $error("head not valid after push");

endmodule

@@ bench/tb_per_cpu_page_free_list.sv @@
`timescale 1ns / 1ps
// Testbench for per_cpu_page_free_list: random and directed free/alloc traffic
// with a built-in free-list predictor and in-order result checking.
// Depends on pcpfl_pkg and the per_cpu_page_free_list RTL.
module tb_per_cpu_page_free_list;
  import pcpfl_pkg::*;

  localparam int CPUS       = 8;
  localparam int PAGES      = 32768;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SH    = 12;
  localparam int PG_W       = 15;
  localparam int WATCHDOG   = 1000;

  typedef struct packed {
    logic                cmd;
    logic [CPU_ID_W-1:0] cpu;
    logic [ADDR_W-1:0]   addr;
  } page_req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] page;
  } page_resp_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_FREE;
  logic [CPU_ID_W-1:0]  in_cpu_id = '0;
  logic [ADDR_W-1:0]    in_phys_addr = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [ADDR_W-1:0]    out_page_addr;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BASE;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  // register shadow, shared by the predictor and the traffic generator
  logic [ADDR_W-1:0] cfg_base = BASE_RST;
  logic [ADDR_W-1:0] cfg_top  = TOP_RST;

  // predicted free lists
  logic [PG_W-1:0] head_pg   [CPUS];
  bit              head_live [CPUS];
  logic [PG_W-1:0] next_pg   [PAGES];
  bit              next_live [PAGES];

  // generator bookkeeping: pages freed since the lists were last all empty
  bit          claimed [PAGES];
  int unsigned claim_log[$];
  int          held = 0;

  page_req_t  pend_q[$];
  page_resp_t resp_q[$];
  page_req_t  cur_req;
  page_resp_t want;
  bit         idle_on = 1'b1;
  int         in_gap = 0;
  int         out_gap = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  per_cpu_page_free_list #(
    .CPU_COUNT (CPUS),
    .PAGE_COUNT(PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_cpu_id    (in_cpu_id),
    .in_phys_addr (in_phys_addr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_page_addr(out_page_addr),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (head_live[i]) head_live[i] = 1'b0;
  end

  function automatic void log_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  // base rounded up to a page boundary; may reach 2**40
  function automatic logic [63:0] first_frame();
    logic [63:0] b;
    b = {24'd0, cfg_base};
    if (b[PAGE_SH-1:0] != '0) b = (b | (PAGE_BYTES - 1)) + 1;
    return b;
  endfunction

  function automatic bit frame_index(input logic [ADDR_W-1:0] a, output int unsigned pg);
    logic [63:0] fp;
    logic [63:0] aa;
    fp = first_frame();
    aa = {24'd0, a};
    pg = 0;
    if (a[PAGE_SH-1:0] != '0 || a < cfg_base || a >= cfg_top || aa < fp) return 1'b0;
    if (((aa - fp) >> PAGE_SH) >= PAGES) return 1'b0;
    pg = int'((aa - fp) >> PAGE_SH);
    return 1'b1;
  endfunction

  function automatic page_resp_t serve_request(input page_req_t rq);
    page_resp_t  r;
    int unsigned pg;
    int          c;
    bit          got;
    r.status = ST_DONE;
    r.page   = '0;
    got      = 1'b0;
    pg       = 0;
    if (rq.cmd == CMD_FREE) begin
      if (!frame_index(rq.addr, pg)) begin
        r.status = ST_BAD;
      end else begin
        next_pg[pg]         = head_pg[rq.cpu];
        next_live[pg]       = head_live[rq.cpu];
        head_pg[rq.cpu]     = PG_W'(pg);
        head_live[rq.cpu]   = 1'b1;
      end
    end else begin
      // own list first, then the others in ascending order
      for (int k = 0; k <= CPUS; k++) begin
        c = (k == 0) ? int'(rq.cpu) : k - 1;
        if (!got && (k == 0 || c != int'(rq.cpu)) && head_live[c]) begin
          pg           = head_pg[c];
          head_pg[c]   = next_pg[pg];
          head_live[c] = next_live[pg];
          got          = 1'b1;
        end
      end
      if (!got) r.status = ST_EMPTY;
      else r.page = ADDR_W'(first_frame() + 64'(pg) * PAGE_BYTES);
    end
    return r;
  endfunction

  task automatic push_req(input logic cmd, input int cpu, input logic [ADDR_W-1:0] addr);
    page_req_t rq;
    rq.cmd  = cmd;
    rq.cpu  = CPU_ID_W'(cpu);
    rq.addr = addr;
    pend_q.push_back(rq);
  endtask

  function automatic void take_page(input int unsigned pg);
    claimed[pg] = 1'b1;
    claim_log.push_back(pg);
    held++;
  endfunction

  // Mostly well-formed traffic: frees of pages not already on a list, allocs,
  // and some invalid frees. Double frees only come from the directed part.
  task automatic add_traffic(input int n, input int free_pct);
    logic [63:0] fp;
    logic [63:0] span;
    logic [63:0] a;
    int unsigned pg;
    int          r;
    bit          ok;
    page_req_t   rq;
    fp   = first_frame();
    span = 0;
    if ({24'd0, cfg_top} > fp) span = ({24'd0, cfg_top} - fp + PAGE_BYTES - 1) >> PAGE_SH;
    if (span > PAGES) span = PAGES;
    for (int i = 0; i < n; i++) begin
      r      = $urandom_range(0, 99);
      rq.cpu = CPU_ID_W'($urandom_range(0, CPUS - 1));
      rq.cmd = CMD_FREE;
      ok     = 1'b0;
      if (r < free_pct && span != 0) begin
        for (int t = 0; t < 8 && !ok; t++) begin
          pg = $urandom_range(0, int'(span) - 1);
          ok = !claimed[pg];
        end
      end
      if (ok) begin
        rq.addr = ADDR_W'(fp + 64'(pg) * PAGE_BYTES);
        take_page(pg);
      end else if (r < 88) begin
        rq.cmd  = CMD_ALLOC;
        rq.addr = ADDR_W'({$urandom, $urandom});
        if (held > 0) begin
          held--;
          if (held == 0) begin
            foreach (claim_log[j]) claimed[claim_log[j]] = 1'b0;
            claim_log.delete();
          end
        end
      end else begin
        case ($urandom_range(0, 3))
          0: a = {$urandom, $urandom};
          1: a = fp + 64'(PAGES + $urandom_range(0, 3)) * PAGE_BYTES;
          2: a = (fp + 64'($urandom_range(0, PAGES - 1)) * PAGE_BYTES) |
                 64'($urandom_range(1, PAGE_BYTES - 1));
          default: a = {24'd0, cfg_base} - 64'($urandom_range(1, 4 * PAGE_BYTES));
        endcase
        rq.addr = a[ADDR_W-1:0];
        if (frame_index(rq.addr, pg)) begin
          // all-ones is never aligned, so it stays an invalid free
          if (claimed[pg]) rq.addr = '1;
          else take_page(pg);
        end
      end
      pend_q.push_back(rq);
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (pend_q.size() != 0 || in_valid || resp_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BASE) cfg_base = val;
    else cfg_top = val;
  endtask

  task automatic set_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] top,
                           input bit idle);
    drain();
    write_reg(REG_BASE, base);
    write_reg(REG_TOP, top);
    idle_on = idle;
    @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) resp_q.push_back(serve_request(cur_req));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          cur_req = pend_q.pop_front();
          in_valid     <= 1'b1;
          in_cmd       <= cur_req.cmd;
          in_cpu_id    <= cur_req.cpu;
          in_phys_addr <= cur_req.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          log_error($sformatf("unexpected result: status %0d page %h",
                              out_status, out_page_addr));
        end else begin
          want = resp_q.pop_front();
          if (out_status !== want.status || out_page_addr !== want.page)
            log_error($sformatf("status %0d page %h, expected status %0d page %h",
                                out_status, out_page_addr, want.status, want.page));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG) begin
      $display("tb_per_cpu_page_free_list: errors");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] rnd_base;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values: empty lists, invalid frees, LIFO order, stealing
    push_req(CMD_ALLOC, 0, '0);
    push_req(CMD_ALLOC, 7, '0);
    push_req(CMD_FREE, 1, BASE_RST + 1);
    push_req(CMD_FREE, 2, BASE_RST + 'h800);
    push_req(CMD_FREE, 4, BASE_RST - PAGE_BYTES);
    push_req(CMD_FREE, 5, TOP_RST);
    push_req(CMD_FREE, 6, '0);
    push_req(CMD_FREE, 7, '1);
    push_req(CMD_FREE, 3, BASE_RST);
    push_req(CMD_FREE, 3, TOP_RST - PAGE_BYTES);
    push_req(CMD_FREE, 5, BASE_RST + 5 * PAGE_BYTES);
    push_req(CMD_ALLOC, 3, '1);
    push_req(CMD_ALLOC, 0, '0);
    push_req(CMD_ALLOC, 1, '0);
    push_req(CMD_ALLOC, 2, '0);
    // same page freed on two CPUs: both lists share one entry
    push_req(CMD_FREE, 6, BASE_RST + 2 * PAGE_BYTES);
    push_req(CMD_FREE, 7, BASE_RST + 2 * PAGE_BYTES);
    push_req(CMD_ALLOC, 6, '0);
    push_req(CMD_ALLOC, 7, '0);
    push_req(CMD_ALLOC, 4, '0);
    push_req(CMD_FREE, 7, BASE_RST + 3 * PAGE_BYTES);
    push_req(CMD_ALLOC, 0, '0);

    // whole address space; page index limit is the only bound
    set_phase('0, '1, 1'b1);
    push_req(CMD_FREE, 0, 40'(PAGES * PAGE_BYTES));
    push_req(CMD_FREE, 1, 40'((PAGES - 1) * PAGE_BYTES));
    push_req(CMD_ALLOC, 2, '0);
    add_traffic(350, 50);

    // unaligned base, pool of seven pages; held pages come back at the new base
    set_phase(40'h12_3456_7ABC, 40'h12_3456_E064, 1'b1);
    add_traffic(250, 50);

    // nothing can be freed; allocs drain what is left
    set_phase('1, '0, 1'b0);
    add_traffic(150, 45);

    rnd_base = {8'($urandom_range(0, 250)), 32'($urandom)} & ~40'hFFF;
    set_phase(rnd_base, rnd_base + 40'd40000 * PAGE_BYTES, 1'b1);
    add_traffic(350, 45);

    set_phase(40'hFFF, '1, 1'b0);
    add_traffic(400, 35);

    drain();
    repeat (8) @(posedge clk);
    mismatches += resp_q.size();
    if (mismatches == 0)
      $display("tb_per_cpu_page_free_list: clean");
    else
      $display("tb_per_cpu_page_free_list: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/pcpfl_pkg.sv
rtl/core/pcpfl_ram.sv
rtl/core/per_cpu_page_free_list.sv
bench/tb_per_cpu_page_free_list.sv
